// ----- rtl/core/ssp_pkg.sv -----
package ssp_pkg;

	// read data packet size on the host link
	localparam int PACKET_BYTES = 64;
	localparam int FILL_W       = $clog2(PACKET_BYTES);

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// longest reply is 33 bytes
	localparam int RIDX_W = 6;

	localparam logic [7:0] ACK      = 8'h06;
	localparam logic [7:0] NAK      = 8'h15;
	localparam logic [7:0] BUS_SPI  = 8'h08;
	localparam logic [7:0] SPI_FILL = 8'hFF;

	localparam logic [7:0] CMD_NOP     = 8'h00;
	localparam logic [7:0] CMD_IFACE   = 8'h01;
	localparam logic [7:0] CMD_MAP     = 8'h02;
	localparam logic [7:0] CMD_NAME    = 8'h03;
	localparam logic [7:0] CMD_BUFSIZE = 8'h04;
	localparam logic [7:0] CMD_BUSTYPE = 8'h05;
	localparam logic [7:0] CMD_SYNC    = 8'h10;
	localparam logic [7:0] CMD_SETBUS  = 8'h12;
	localparam logic [7:0] CMD_SPIOP   = 8'h13;

	localparam logic [7:0] NAME_BYTES [16] = '{
		8'h63, 8'h68, 8'h35, 8'h35, 8'h32, 8'h2D, 8'h73, 8'h65,
		8'h72, 8'h70, 8'h72, 8'h6F, 8'h67, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BUSARG,
		PH_LEN,
		PH_WRITE,
		PH_READ
	} ssp_phase_t;

	typedef enum logic [1:0] {
		JOB_ONE,
		JOB_TWO,
		JOB_REPLY
	} ssp_job_kind_t;

	typedef enum logic [2:0] {
		RPL_ACK,
		RPL_NAK,
		RPL_IFACE,
		RPL_MAP,
		RPL_NAME,
		RPL_BUFSIZE,
		RPL_BUSTYPE,
		RPL_SYNC
	} ssp_reply_t;

	typedef struct packed {
		logic       host_valid;
		logic [7:0] host_byte;
		logic       host_last;
		logic       spi_valid;
		logic [7:0] spi_byte;
		logic       spi_capture;
		logic       chip_select_low;
		logic       phase_error;
	} ssp_res_t;

	typedef struct packed {
		ssp_job_kind_t kind;
		ssp_reply_t    reply;
		ssp_res_t      res0;
		ssp_res_t      res1;
	} ssp_job_t;

	function automatic logic [RIDX_W-1:0] reply_len(ssp_reply_t r);
		case (r)
			RPL_ACK:     reply_len = RIDX_W'(1);
			RPL_NAK:     reply_len = RIDX_W'(1);
			RPL_IFACE:   reply_len = RIDX_W'(3);
			RPL_MAP:     reply_len = RIDX_W'(33);
			RPL_NAME:    reply_len = RIDX_W'(17);
			RPL_BUFSIZE: reply_len = RIDX_W'(3);
			RPL_BUSTYPE: reply_len = RIDX_W'(2);
			RPL_SYNC:    reply_len = RIDX_W'(2);
			default:     reply_len = RIDX_W'(1);
		endcase
	endfunction

	function automatic logic [7:0] reply_byte(ssp_reply_t r, logic [RIDX_W-1:0] idx);
		logic [RIDX_W-1:0] nidx;
		nidx = idx - RIDX_W'(1);
		reply_byte = ACK;
		case (r)
			RPL_ACK: reply_byte = ACK;
			RPL_NAK: reply_byte = NAK;
			RPL_IFACE: begin
				if (idx == RIDX_W'(1))
					reply_byte = 8'h01;
				else if (idx != '0)
					reply_byte = 8'h00;
			end
			RPL_MAP: begin
				case (idx)
					RIDX_W'(0): reply_byte = ACK;
					RIDX_W'(1): reply_byte = 8'h3F;
					RIDX_W'(3): reply_byte = 8'h0D;
					default:    reply_byte = 8'h00;
				endcase
			end
			RPL_NAME: begin
				if (idx != '0)
					reply_byte = NAME_BYTES[nidx[3:0]];
			end
			RPL_BUFSIZE: begin
				if (idx != '0)
					reply_byte = 8'hFF;
			end
			RPL_BUSTYPE: begin
				if (idx != '0)
					reply_byte = BUS_SPI;
			end
			RPL_SYNC: reply_byte = (idx == '0) ? NAK : ACK;
			default: reply_byte = NAK;
		endcase
	endfunction

endpackage

// ----- rtl/core/ssp_cmd_if.sv -----
interface ssp_cmd_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data;

	modport source (output valid, mode, data, input ready);
	modport sink (input valid, mode, data, output ready);
endinterface

// ----- rtl/core/ssp_rsp_if.sv -----
interface ssp_rsp_if;
	logic       valid;
	logic       ready;
	logic       host_valid;
	logic [7:0] host_byte;
	logic       host_last;
	logic       spi_valid;
	logic [7:0] spi_byte;
	logic       spi_capture;
	logic       chip_select_low;
	logic       phase_error;
	logic       run_end;

	modport source (output valid, host_valid, host_byte, host_last, spi_valid, spi_byte,
		spi_capture, chip_select_low, phase_error, run_end, input ready);
	modport sink (input valid, host_valid, host_byte, host_last, spi_valid, spi_byte,
		spi_capture, chip_select_low, phase_error, run_end, output ready);
endinterface

// ----- rtl/core/ssp_front.sv -----
module ssp_front import ssp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ssp_cmd_if.sink   cmd,
	output logic      push_valid,
	output ssp_job_t  push_job,
	input  logic      push_ready
);

	ssp_phase_t phase_q, phase_d;
	logic [2:0]        len_idx_q, len_idx_d;
	logic [23:0]       write_left_q, write_left_d;
	logic [23:0]       read_left_q, read_left_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              select_q, select_d;

	logic              fire;
	logic              misplaced;
	logic [23:0]       w_len, r_len, w_dec, r_dec;
	logic              len_last;
	logic [FILL_W:0]   fill_sum;
	logic              full;

	assign cmd.ready  = push_ready;
	assign push_valid = cmd.valid;
	assign fire       = cmd.valid && push_ready;

	// host bytes are not taken in the read phase, captured bytes only there
	assign misplaced = ((phase_q == PH_READ) == (cmd.mode == 1'b0));

	assign len_last = (len_idx_q == 3'd5);
	assign w_dec    = write_left_q - 24'd1;
	assign r_dec    = read_left_q - 24'd1;
	assign fill_sum = {1'b0, fill_q} + (FILL_W+1)'(1);
	assign full     = (fill_sum >= (FILL_W+1)'(PACKET_BYTES));

	// counts are gathered little endian, write first
	always_comb begin
		w_len = write_left_q;
		r_len = read_left_q;
		case (len_idx_q)
			3'd0: w_len[7:0]   = write_left_q[7:0] | cmd.data;
			3'd1: w_len[15:8]  = write_left_q[15:8] | cmd.data;
			3'd2: w_len[23:16] = write_left_q[23:16] | cmd.data;
			3'd3: r_len[7:0]   = read_left_q[7:0] | cmd.data;
			3'd4: r_len[15:8]  = read_left_q[15:8] | cmd.data;
			3'd5: r_len[23:16] = read_left_q[23:16] | cmd.data;
			default: ;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		if (fire && !misplaced) begin
			case (phase_q)
				PH_BUSARG: phase_d = PH_IDLE;
				PH_LEN: begin
					if (len_last) begin
						if (w_len != '0)
							phase_d = PH_WRITE;
						else if (r_len != '0)
							phase_d = PH_READ;
						else
							phase_d = PH_IDLE;
					end
				end
				PH_WRITE: begin
					if (w_dec == '0)
						phase_d = (read_left_q != '0) ? PH_READ : PH_IDLE;
				end
				PH_READ: begin
					if (r_dec == '0)
						phase_d = PH_IDLE;
				end
				PH_IDLE: begin
					if (cmd.data == CMD_SETBUS)
						phase_d = PH_BUSARG;
					else if (cmd.data == CMD_SPIOP)
						phase_d = PH_LEN;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		len_idx_d    = len_idx_q;
		write_left_d = write_left_q;
		read_left_d  = read_left_q;
		fill_d       = fill_q;
		select_d     = select_q;

		push_job                      = '0;
		push_job.kind                 = JOB_ONE;
		push_job.reply                = RPL_ACK;
		push_job.res0.chip_select_low = select_q;

		if (misplaced) begin
			push_job.res0.phase_error = 1'b1;
		end else begin
			case (phase_q)
				PH_BUSARG: begin
					push_job.kind  = JOB_REPLY;
					push_job.reply = ((cmd.data | BUS_SPI) == BUS_SPI) ? RPL_ACK : RPL_NAK;
				end
				PH_LEN: begin
					write_left_d = w_len;
					read_left_d  = r_len;
					len_idx_d    = len_idx_q + 3'd1;
					if (len_last) begin
						len_idx_d = '0;
						fill_d    = '0;
						if (w_len != '0) begin
							select_d                      = 1'b1;
							push_job.res0.chip_select_low = 1'b1;
						end else if (r_len != '0) begin
							select_d                      = 1'b1;
							push_job.res0.spi_valid       = 1'b1;
							push_job.res0.spi_byte        = SPI_FILL;
							push_job.res0.spi_capture     = 1'b1;
							push_job.res0.chip_select_low = 1'b1;
						end else begin
							select_d                      = 1'b0;
							push_job.res0.chip_select_low = 1'b0;
						end
					end
				end
				PH_WRITE: begin
					write_left_d                  = w_dec;
					push_job.res0.spi_valid       = 1'b1;
					push_job.res0.spi_byte        = cmd.data;
					push_job.res0.chip_select_low = 1'b1;
					if (w_dec == '0) begin
						push_job.kind = JOB_TWO;
						if (read_left_q != '0) begin
							push_job.res1.spi_valid       = 1'b1;
							push_job.res1.spi_byte        = SPI_FILL;
							push_job.res1.spi_capture     = 1'b1;
							push_job.res1.chip_select_low = 1'b1;
						end else begin
							select_d = 1'b0;
						end
					end
				end
				PH_READ: begin
					read_left_d              = r_dec;
					fill_d                   = full ? '0 : fill_sum[FILL_W-1:0];
					push_job.res0.host_valid = 1'b1;
					push_job.res0.host_byte  = cmd.data;
					if (r_dec != '0) begin
						push_job.res0.host_last       = full;
						push_job.res0.spi_valid       = 1'b1;
						push_job.res0.spi_byte        = SPI_FILL;
						push_job.res0.spi_capture     = 1'b1;
						push_job.res0.chip_select_low = 1'b1;
					end else begin
						select_d                = 1'b0;
						fill_d                  = '0;
						push_job.res0.host_last = 1'b1;
						if (full) begin
							// exact multiple: close with a zero-length packet
							push_job.kind                 = JOB_TWO;
							push_job.res0.chip_select_low = 1'b1;
							push_job.res1.host_last       = 1'b1;
						end else begin
							push_job.res0.chip_select_low = 1'b0;
						end
					end
				end
				PH_IDLE: begin
					push_job.kind = JOB_REPLY;
					case (cmd.data)
						CMD_NOP:     push_job.reply = RPL_ACK;
						CMD_IFACE:   push_job.reply = RPL_IFACE;
						CMD_MAP:     push_job.reply = RPL_MAP;
						CMD_NAME:    push_job.reply = RPL_NAME;
						CMD_BUFSIZE: push_job.reply = RPL_BUFSIZE;
						CMD_BUSTYPE: push_job.reply = RPL_BUSTYPE;
						CMD_SYNC:    push_job.reply = RPL_SYNC;
						CMD_SETBUS:  push_job.kind  = JOB_ONE;
						CMD_SPIOP: begin
							push_job.reply = RPL_ACK;
							len_idx_d      = '0;
							write_left_d   = '0;
							read_left_d    = '0;
						end
						default:     push_job.reply = RPL_NAK;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			len_idx_q    <= '0;
			write_left_q <= '0;
			read_left_q  <= '0;
			fill_q       <= '0;
			select_q     <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			len_idx_q    <= len_idx_d;
			write_left_q <= write_left_d;
			read_left_q  <= read_left_d;
			fill_q       <= fill_d;
			select_q     <= select_d;
		end
	end

`ifndef SYNTH
	a_write_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WRITE |-> select_q && write_left_q != '0)
		else $error("write phase with nothing left to write");
	a_read_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_READ |-> select_q && read_left_q != '0)
		else $error("read phase with nothing left to read");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !select_q && len_idx_q == '0)
		else $error("idle with chip select or count index left over");
`endif

endmodule

// ----- rtl/core/ssp_queue.sv -----
module ssp_queue import ssp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	input  ssp_job_t push_job,
	output logic     push_ready,
	output logic     pop_valid,
	output ssp_job_t pop_job,
	input  logic     pop_ready
);

	ssp_job_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push_fire, pop_fire;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_ready && pop_valid;

	always_ff @(posedge clk) begin
		if (push_fire)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop_fire)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push_fire && !pop_fire)
				count_q <= count_q + QCNT_W'(1);
			else if (pop_fire && !push_fire)
				count_q <= count_q - QCNT_W'(1);
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("job queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push_fire && !pop_fire |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("job queue lost a push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire && !push_fire |=> count_q == $past(count_q) - QCNT_W'(1))
		else $error("job queue lost a pop");
`endif

endmodule

// ----- rtl/core/ssp_back.sv -----
module ssp_back import ssp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	input  ssp_job_t pop_job,
	output logic     pop_ready,
	ssp_rsp_if.source rsp
);

	logic [RIDX_W-1:0] idx_q;
	logic [RIDX_W-1:0] rlen;
	ssp_res_t          cur;
	logic              cur_last;
	logic              load;

	ssp_res_t          out_res_q;
	logic              out_valid_q;
	logic              out_end_q;

	assign rlen = reply_len(pop_job.reply);

	always_comb begin
		cur      = pop_job.res0;
		cur_last = 1'b1;
		case (pop_job.kind)
			JOB_ONE: begin
				cur      = pop_job.res0;
				cur_last = 1'b1;
			end
			JOB_TWO: begin
				cur      = idx_q[0] ? pop_job.res1 : pop_job.res0;
				cur_last = idx_q[0];
			end
			JOB_REPLY: begin
				cur_last            = (idx_q == rlen - RIDX_W'(1));
				cur                 = '0;
				cur.host_valid      = 1'b1;
				cur.host_byte       = reply_byte(pop_job.reply, idx_q);
				cur.host_last       = cur_last;
				cur.chip_select_low = pop_job.res0.chip_select_low;
			end
			default: ;
		endcase
	end

	assign load      = pop_valid && (!out_valid_q || rsp.ready);
	assign pop_ready = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= cur_last ? '0 : idx_q + RIDX_W'(1);
			if (load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= cur;
			out_end_q <= cur_last;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.host_valid      = out_res_q.host_valid;
	assign rsp.host_byte       = out_res_q.host_byte;
	assign rsp.host_last       = out_res_q.host_last;
	assign rsp.spi_valid       = out_res_q.spi_valid;
	assign rsp.spi_byte        = out_res_q.spi_byte;
	assign rsp.spi_capture     = out_res_q.spi_capture;
	assign rsp.chip_select_low = out_res_q.chip_select_low;
	assign rsp.phase_error     = out_res_q.phase_error;
	assign rsp.run_end         = out_end_q;

`ifndef SYNTH
	a_reply_idx: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_job.kind == JOB_REPLY |-> idx_q < rlen)
		else $error("reply index past reply length");
	a_pair_idx: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_job.kind == JOB_TWO |-> idx_q <= RIDX_W'(1))
		else $error("two-result job index out of range");
	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.phase_error |-> out_end_q)
		else $error("dropped item result not marked as run end");
	a_idx_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready |=> idx_q == '0)
		else $error("index not rewound after job done");
`endif

endmodule

// ----- rtl/core/serial_spi_flash_programmer_top.sv -----
// The first result of an item passes the job queue and then the output register before
//   it is shown, when nothing waits ahead. One result per cycle leaves the back end while
//   rsp is ready; an item has 1, 2, or up to 33 results (the command map reply). Items
//   are taken every cycle while the 4-entry job queue has room. Reset (arst_n low) idles
//   the protocol, releases chip select and empties the queue and output register.
module serial_spi_flash_programmer_top import ssp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ssp_cmd_if.sink   cmd,
	ssp_rsp_if.source rsp
);

	// Front end: decodes each item against the protocol phase, updates the
	// counts, packet fill and chip select, and turns the item into one job
	// (one result, two results, or a canned reply by code).
	logic     push_valid;
	logic     push_ready;
	ssp_job_t push_job;

	// Back end: expands the job at the queue head into results, one per
	// cycle, into an output register that keeps the result while rsp stalls.
	logic     pop_valid;
	logic     pop_ready;
	ssp_job_t pop_job;

	ssp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	// Queue decouples the two: long replies stall the back end only, and
	// the front keeps taking items until the queue fills.
	ssp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	ssp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule
